>>> sv/indexed_port_ram_window_macros.svh
// Assertion helpers; build with ASSERT_OFF defined to drop them.
`ifndef INDEXED_PORT_RAM_WINDOW_MACROS_SVH
`define INDEXED_PORT_RAM_WINDOW_MACROS_SVH

`ifndef ASSERT_OFF

// antecedent |-> consequent in the same cycle
`define IPRW_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// antecedent |=> consequent in the next cycle
`define IPRW_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`else

`define IPRW_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define IPRW_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

>>> sv/iprw_pkg.sv
package iprw_pkg;

  localparam int unsigned DATA_W = 8;

  typedef logic [DATA_W-1:0] byte_t;
  typedef logic [15:0]       ofs_t;
  typedef logic [1:0]        cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t CFG_INDEX_PORT = 2'd0;
  localparam cfg_idx_t CFG_WIN_PORT   = 2'd1;
  localparam cfg_idx_t CFG_CMD_INDEX  = 2'd2;

  // configuration reset values
  localparam byte_t RST_INDEX_PORT = 8'h4E;
  localparam byte_t RST_WIN_PORT   = 8'h4F;
  localparam byte_t RST_CMD_INDEX  = 8'h2E;

  // command types
  localparam byte_t TYPE_OFS_LOW  = 8'h10;
  localparam byte_t TYPE_OFS_HIGH = 8'h11;
  localparam byte_t TYPE_VALUE    = 8'h12;

  localparam byte_t RDATA_NONE = 8'hFF;
  localparam byte_t RDATA_WR   = 8'h00;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_INDEX,
    ACC_TYPE,
    ACC_OFS_LO,
    ACC_OFS_HI,
    ACC_RAM
  } acc_kind_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ram_ctl_t;

endpackage

>>> sv/iprw_ram.sv
module iprw_ram
  import iprw_pkg::*;
#(
  parameter int unsigned ADDR_BITS = 16
) (
  input  logic                 clk,
  input  ram_ctl_t             ctl,
  input  logic [ADDR_BITS-1:0] addr,
  input  byte_t                wdata,
  output byte_t                rdata
);

  localparam int unsigned DEPTH = 1 << ADDR_BITS;

  byte_t mem [DEPTH];
  byte_t rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wdata;
    end
  end

  // registered read; data holds until the next read
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/indexed_port_ram_window.sv
// Indexed port RAM window: device side of an index/data port pair.
// Input channel (in_valid/in_ready): one byte bus access per transaction,
//   in_cmd 1 = write, 0 = read, on port in_port with byte in_wdata.
// Output channel (out_valid/out_ready): one result per access, out_rdata
//   and out_decoded (access hit a known port and register).
// Config channel (cfg_valid/cfg_ready): cfg_index 0 index port address,
//   1 data port address, 2 command index; always ready. Write only when idle.
// Result timing: the result is registered and appears in the cycle after the
//   access is accepted; RAM read data comes from the RAM's registered read port.
// Throughput: one access per cycle when out_ready is high; a new access is
//   taken in the cycle the last result is taken: back-to-back at full rate.
// Stall: while out_valid is high and out_ready low, the result and the RAM
//   read data hold and in_ready stays low.
// Reset (rst_n low, synchronous): config registers return to 0x4E, 0x4F,
//   0x2E; index, type and offset clear to zero. RAM contents are undefined
//   until written; no clearing pass is run.
module indexed_port_ram_window
  import iprw_pkg::*;
#(
  parameter int unsigned RAM_ADDR_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_cmd,
  input  byte_t    in_port,
  input  byte_t    in_wdata,
  output logic     out_valid,
  input  logic     out_ready,
  output byte_t    out_rdata,
  output logic     out_decoded,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  cfg_idx_t cfg_index,
  input  byte_t    cfg_data
);

`include "indexed_port_ram_window_macros.svh"

  byte_t index_port_r, index_port_nxt;
  byte_t win_port_r, win_port_nxt;
  byte_t cmd_index_r, cmd_index_nxt;

  byte_t index_reg_r, index_reg_nxt;
  byte_t type_reg_r, type_reg_nxt;
  ofs_t  ram_offset_r, ram_offset_nxt;

  logic  out_valid_r, out_valid_nxt;
  byte_t out_rdata_r, out_rdata_nxt;
  logic  out_decoded_r, out_decoded_nxt;
  logic  out_from_ram_r, out_from_ram_nxt;

  logic      in_fire;
  logic      cfg_fire;
  byte_t     arg_index;
  acc_kind_t kind;
  ram_ctl_t  ram_ctl;
  byte_t     ram_rdata;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid & in_ready;
  assign arg_index = cmd_index_r + 8'd1;

  // configuration register decode
  always_comb begin
    index_port_nxt = index_port_r;
    win_port_nxt   = win_port_r;
    cmd_index_nxt  = cmd_index_r;
    if (cfg_fire) begin
      unique case (cfg_index)
        CFG_INDEX_PORT: index_port_nxt = cfg_data;
        CFG_WIN_PORT:   win_port_nxt   = cfg_data;
        CFG_CMD_INDEX:  cmd_index_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  // access decode
  always_comb begin
    kind = ACC_NONE;
    if (in_port == index_port_r) begin
      kind = ACC_INDEX;
    end else if (in_port == win_port_r) begin
      if (index_reg_r == cmd_index_r) begin
        kind = ACC_TYPE;
      end else if (index_reg_r == arg_index) begin
        unique case (type_reg_r)
          TYPE_OFS_LOW:  kind = in_cmd ? ACC_OFS_LO : ACC_NONE;
          TYPE_OFS_HIGH: kind = in_cmd ? ACC_OFS_HI : ACC_NONE;
          TYPE_VALUE:    kind = ACC_RAM;
          default:       kind = ACC_NONE;
        endcase
      end
    end
  end

  // state update and result capture
  always_comb begin
    index_reg_nxt    = index_reg_r;
    type_reg_nxt     = type_reg_r;
    ram_offset_nxt   = ram_offset_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_rdata_nxt    = out_rdata_r;
    out_decoded_nxt  = out_decoded_r;
    out_from_ram_nxt = out_from_ram_r;
    ram_ctl.wr_en    = 1'b0;
    ram_ctl.rd_en    = 1'b0;
    if (in_fire) begin
      out_valid_nxt    = 1'b1;
      out_decoded_nxt  = (kind != ACC_NONE);
      out_from_ram_nxt = 1'b0;
      out_rdata_nxt    = in_cmd ? RDATA_WR : RDATA_NONE;
      unique case (kind)
        ACC_INDEX: begin
          if (in_cmd) begin
            index_reg_nxt = in_wdata;
          end else begin
            out_rdata_nxt = index_reg_r;
          end
        end
        ACC_TYPE: begin
          if (in_cmd) begin
            type_reg_nxt = in_wdata;
          end else begin
            out_rdata_nxt = type_reg_r;
          end
        end
        ACC_OFS_LO: ram_offset_nxt = {ram_offset_r[15:8], in_wdata};
        ACC_OFS_HI: ram_offset_nxt = {in_wdata, ram_offset_r[7:0]};
        ACC_RAM: begin
          ram_ctl.wr_en    = in_cmd;
          ram_ctl.rd_en    = !in_cmd;
          out_from_ram_nxt = !in_cmd;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_port_r   <= RST_INDEX_PORT;
      win_port_r     <= RST_WIN_PORT;
      cmd_index_r    <= RST_CMD_INDEX;
      index_reg_r    <= '0;
      type_reg_r     <= '0;
      ram_offset_r   <= '0;
      out_valid_r    <= 1'b0;
      out_from_ram_r <= 1'b0;
    end else begin
      index_port_r   <= index_port_nxt;
      win_port_r     <= win_port_nxt;
      cmd_index_r    <= cmd_index_nxt;
      index_reg_r    <= index_reg_nxt;
      type_reg_r     <= type_reg_nxt;
      ram_offset_r   <= ram_offset_nxt;
      out_valid_r    <= out_valid_nxt;
      out_from_ram_r <= out_from_ram_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rdata_r   <= out_rdata_nxt;
    out_decoded_r <= out_decoded_nxt;
  end

  iprw_ram #(
    .ADDR_BITS(RAM_ADDR_BITS)
  ) u_ram (
    .clk  (clk),
    .ctl  (ram_ctl),
    .addr (ram_offset_r[RAM_ADDR_BITS-1:0]),
    .wdata(in_wdata),
    .rdata(ram_rdata)
  );

  assign out_valid   = out_valid_r;
  assign out_rdata   = out_from_ram_r ? ram_rdata : out_rdata_r;
  assign out_decoded = out_decoded_r;

  `IPRW_ASSERT_NXT(a_ram_rd_result, clk, rst_n, in_fire && ram_ctl.rd_en,
    out_valid_r && out_from_ram_r, "RAM read did not produce a RAM result")
  `IPRW_ASSERT_IMP(a_ram_result_decoded, clk, rst_n, out_valid_r && out_from_ram_r,
    out_decoded_r, "RAM result not flagged as decoded")
  `IPRW_ASSERT_NXT(a_write_rdata_zero, clk, rst_n, in_fire && in_cmd,
    out_rdata == RDATA_WR && !out_from_ram_r, "write transaction returned nonzero data")
  `IPRW_ASSERT_NXT(a_index_latch, clk, rst_n, in_fire && in_cmd && kind == ACC_INDEX,
    index_reg_r == $past(in_wdata), "index register did not latch written byte")

endmodule
